@@ rtl/banked_plane_masked_video_ram_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for banked_plane_masked_video_ram_core
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef BANKED_PLANE_MASKED_VIDEO_RAM_CORE_ASSERT_SVH
`define BANKED_PLANE_MASKED_VIDEO_RAM_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPMVR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BPMVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/bpmvr_pkg.sv @@
// ----------------------------------------------------------------------------
// bpmvr_pkg
// Shared constants and types of the banked, plane-masked video RAM core.
// ----------------------------------------------------------------------------
package bpmvr_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // Bus decode
   localparam logic [15:0] WIN_BASE   = 16'hd000;
   localparam logic [15:0] WIN_SELECT = 16'hf800;
   localparam logic [15:0] REG_TILES  = 16'hc000;
   localparam logic [15:0] REG_FLIP   = 16'he301;
   localparam logic [15:0] REG_BANK   = 16'he401;
   localparam logic [15:0] REG_SCR_C  = 16'he402;
   localparam logic [15:0] REG_SCR_L  = 16'he403;
   localparam logic [15:0] PULSE_NMI  = 16'hc0c0;
   localparam logic [15:0] PULSE_IRQC = 16'hc0c1;
   localparam logic [15:0] PULSE_NMIC = 16'he417;

   // Tile bank writes with this bit set are ignored
   localparam logic [7:0] TILE_LOCK = 8'h04;

   typedef enum logic {
      ACCESS_READ  = 1'b0,
      ACCESS_WRITE = 1'b1
   } access_type;

   typedef struct packed {
      logic clear_we;
      logic accept;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   // Result word, read_data in the lowest bits
   typedef struct packed {
      logic [8:0] bg_scroll;
      logic       bg_enable;
      logic [1:0] tile_bank;
      logic       flip_screen;
      logic       own_nmi_clear;
      logic       own_irq_clear;
      logic       main_nmi_pulse;
      logic [7:0] read_data;
   } rsp_word_type;

endpackage

@@ rtl/bpmvr_ram.sv @@
// ----------------------------------------------------------------------------
// bpmvr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpmvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bpmvr_dpath.sv @@
// ----------------------------------------------------------------------------
// bpmvr_dpath
// Request capture, store access, register decode and result register.
// ----------------------------------------------------------------------------
module bpmvr_dpath #(
   parameter int HALF_BYTES = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bpmvr_pkg::cmd_type                    cmd,
   output bpmvr_pkg::status_type                 status,
   input  logic [bpmvr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                  req_tuser,
   output logic [bpmvr_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import bpmvr_pkg::*;

   localparam int OFF_W  = $clog2(HALF_BYTES);
   localparam int DEPTH  = 2 * HALF_BYTES;
   localparam int RAM_AW = $clog2(DEPTH);

   logic [15:0]       in_addr;
   logic [7:0]        in_data;
   logic              in_window;

   access_type        access_ff;
   logic [15:0]       addr_ff;
   logic [7:0]        data_ff;

   logic [RAM_AW-1:0] clear_cnt_ff;
   logic [RAM_AW-1:0] clear_cnt_in;

   logic              direct_bank_ff, direct_bank_in;
   logic [7:0]        plane_mask_ff, plane_mask_in;
   logic [1:0]        bank_tiles_ff, bank_tiles_in;
   logic              flip_ff, flip_in;
   logic [7:0]        scroll_control_ff, scroll_control_in;
   logic [7:0]        scroll_low_ff, scroll_low_in;

   logic              win_hit;
   logic              is_write;
   logic              reg_write;
   logic [7:0]        merged;

   logic              ram_wr_en;
   logic [RAM_AW-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [RAM_AW-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   rsp_word_type      rsp_word_ff;
   rsp_word_type      rsp_word_in;

   // Incoming word
   assign in_addr   = req_tdata[15:0];
   assign in_data   = req_tdata[23:16];
   assign in_window = (in_addr & WIN_SELECT) == WIN_BASE;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         access_ff <= access_type'(req_tuser);
         addr_ff   <= in_addr;
         data_ff   <= in_data;
      end
   end

   // Clear sweep counter
   assign clear_cnt_in      = cmd.clear_we ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
   assign status.clear_last = clear_cnt_ff == RAM_AW'(DEPTH - 1);

   // Store: read on accept, merge and write back on advance
   assign ram_rd_en   = cmd.accept & in_window;
   assign ram_rd_addr = {~direct_bank_ff, in_addr[OFF_W-1:0]};

   assign win_hit   = (addr_ff & WIN_SELECT) == WIN_BASE;
   assign is_write  = access_ff == ACCESS_WRITE;
   assign reg_write = cmd.advance & is_write & ~win_hit;
   assign merged    = direct_bank_ff ? data_ff
                    : (ram_rd_data & ~plane_mask_ff) | (data_ff & plane_mask_ff);

   assign ram_wr_en   = cmd.clear_we | (cmd.advance & win_hit & is_write);
   assign ram_wr_addr = cmd.clear_we ? clear_cnt_ff : {~direct_bank_ff, addr_ff[OFF_W-1:0]};
   assign ram_wr_data = cmd.clear_we ? 8'h00 : merged;

   bpmvr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Register decode
   always_comb begin
      direct_bank_in    = direct_bank_ff;
      plane_mask_in     = plane_mask_ff;
      bank_tiles_in     = bank_tiles_ff;
      flip_in           = flip_ff;
      scroll_control_in = scroll_control_ff;
      scroll_low_in     = scroll_low_ff;
      if (reg_write) begin
         unique case (addr_ff)
            REG_TILES: begin
               if ((data_ff & TILE_LOCK) == 8'h00) begin
                  bank_tiles_in = data_ff[1:0];
               end
            end
            REG_FLIP: begin
               flip_in = data_ff[0];
            end
            REG_BANK: begin
               direct_bank_in = data_ff[0];
               if (!data_ff[0]) begin
                  plane_mask_in = (data_ff[7:4] == 4'h0) ? (8'h01 << data_ff[3:1]) : 8'h00;
               end
            end
            REG_SCR_C: begin
               scroll_control_in = data_ff;
            end
            REG_SCR_L: begin
               scroll_low_in = data_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Result word carries the display state after the access
   always_comb begin
      rsp_word_in.read_data      = (win_hit && !is_write) ? ram_rd_data : 8'h00;
      rsp_word_in.main_nmi_pulse = is_write && (addr_ff == PULSE_NMI);
      rsp_word_in.own_irq_clear  = is_write && (addr_ff == PULSE_IRQC);
      rsp_word_in.own_nmi_clear  = is_write && (addr_ff == PULSE_NMIC);
      rsp_word_in.flip_screen    = flip_in;
      rsp_word_in.tile_bank      = bank_tiles_in;
      rsp_word_in.bg_enable      = scroll_control_in[3];
      rsp_word_in.bg_scroll      = {scroll_control_in[1], scroll_low_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff      <= '0;
         direct_bank_ff    <= 1'b1;
         plane_mask_ff     <= 8'h00;
         bank_tiles_ff     <= 2'b00;
         flip_ff           <= 1'b0;
         scroll_control_ff <= 8'h00;
         scroll_low_ff     <= 8'h00;
      end else begin
         clear_cnt_ff      <= clear_cnt_in;
         direct_bank_ff    <= direct_bank_in;
         plane_mask_ff     <= plane_mask_in;
         bank_tiles_ff     <= bank_tiles_in;
         flip_ff           <= flip_in;
         scroll_control_ff <= scroll_control_in;
         scroll_low_ff     <= scroll_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tdata = rsp_word_ff;

endmodule

@@ rtl/bpmvr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpmvr_ctrl
// Sequencer: clear sweep, accept, read-modify-write step, result handoff.
// ----------------------------------------------------------------------------
module bpmvr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  bpmvr_pkg::status_type status,
   output bpmvr_pkg::cmd_type    cmd
);
   import bpmvr_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.clear_we = state_ff == ST_CLEAR;
      cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.advance  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (cmd.accept)        state_in = ST_EXEC;
         ST_EXEC:  if (cmd.advance)       state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   assign rsp_valid_in = cmd.advance | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ rtl/banked_plane_masked_video_ram_core.sv @@
// ----------------------------------------------------------------------------
// banked_plane_masked_video_ram_core
// Background video RAM with bank select and plane-masked writes, sub-CPU side.
// ----------------------------------------------------------------------------
// Usage:
//   Each req word is one bus access: tuser = read/write, tdata = address and
//   write byte. Each access returns exactly one rsp word with the read byte,
//   the three interrupt pulses and the display state after the access.
//   Window 0xd000-0xd7ff hits the low half of the store in bank 1 and the
//   high half in bank 0; bank-0 writes merge under the plane mask.
//   A taken req word moves the sequencer to EXEC; its advance step registers
//   the result word and raises rsp_tvalid, waiting while an older result is
//   held. No new req word is taken until the read-modify-write of the single
//   store RAM (read on accept, merge and write back on advance) is done.
//   Reset: a clear sweep writes zero to every store byte, one byte a cycle,
//   2*HALF_BYTES bytes (4096 at the default); req_tready stays low meanwhile.
//   Stall: a finished word waits in the output register; the next req word
//   is still taken, and its update step holds until that register drains.
// ----------------------------------------------------------------------------
module banked_plane_masked_video_ram_core #(
   parameter int HALF_BYTES = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] bus_address, [23:16] write_data
   input  logic [bpmvr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type (0 read, 1 write)
   input  logic                              req_tuser,
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] read_data, [8] main_nmi_pulse, [9] own_irq_clear,
   // [10] own_nmi_clear, [11] flip_screen, [13:12] tile_bank,
   // [14] bg_enable, [23:15] bg_scroll
   output logic [bpmvr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bpmvr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: owns handshakes and the output valid flag
   bpmvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: store, display registers and result register
   bpmvr_dpath #(
      .HALF_BYTES(HALF_BYTES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tdata(rsp_tdata)
   );

endmodule

@@ rtl/bpmvr_checker.sv @@
// ----------------------------------------------------------------------------
// bpmvr_checker
// Port-level checks of the video RAM core, bound to the top level.
// ----------------------------------------------------------------------------
`include "banked_plane_masked_video_ram_core_assert.svh"

module bpmvr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [bpmvr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bpmvr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bpmvr_pkg::*;

   logic [REQ_TDATA_W:0] req_word;
   assign req_word = {req_tuser, req_tdata};

   // Clear sweep starts at reset: no words either way
   `BPMVR_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !req_tready && !rsp_tvalid)

   // An access holds the sequencer in EXEC: no accept right after an accept
   `BPMVR_ASSERT_NEXT(a_accept_spacing, clock, reset,
                      req_tvalid && req_tready && (req_word == req_word), !req_tready)

   // A stalled result holds
   `BPMVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                      rsp_tvalid && $stable(rsp_tdata))

   // Pulse addresses are distinct: at most one pulse per word
   `BPMVR_ASSERT_IMPL(a_one_pulse, clock, reset, rsp_tvalid, $countones(rsp_tdata[10:8]) <= 1)

endmodule

bind banked_plane_masked_video_ram_core bpmvr_checker u_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banked, plane-masked video RAM core. Bus
// accesses go in as req words, and a local copy of the store and display
// registers works out each rsp word. Every rsp word is checked field by field
// in arrival order. The sender runs in random bursts and the receiver stalls
// on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import bpmvr_pkg::*;

   localparam int HALF_BYTES   = 2048;
   localparam int STORE_BYTES  = 2 * HALF_BYTES;
   localparam int RANDOM_WORDS = 925;
   // Clear sweep after reset, then about a thousand words slowed by gaps and
   // stalls; the limit allows for that many times over.
   localparam int CYCLE_LIMIT  = 300000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [15:0] bus_address, [23:16] write_data
   logic                   req_tuser;   // [0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] read_data, [8] main_nmi_pulse, [9] own_irq_clear, [10] own_nmi_clear,
   // [11] flip_screen, [13:12] tile_bank, [14] bg_enable, [23:15] bg_scroll
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Local image of the block state
   logic [7:0] vram_img [STORE_BYTES];
   logic       bank_direct;
   logic [7:0] plane_sel;
   logic [1:0] tile_sel;
   logic       flip_q;
   logic [7:0] scroll_ctl;
   logic [7:0] scroll_lo;

   rsp_word_type expected_words[$];

   int unsigned mismatch_cnt = 0;
   int unsigned checked_cnt  = 0;
   int unsigned cycle_cnt    = 0;
   int unsigned burst_left   = 0;
   bit          sender_steady = 1'b0;

   banked_plane_masked_video_ram_core #(
      .HALF_BYTES (HALF_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Bring the local image to its post-reset state: store cleared, bank 1.
   function automatic void clear_image();
      for (int i = 0; i < STORE_BYTES; i++)
         vram_img[i] = 8'h00;
      bank_direct = 1'b1;
      plane_sel   = 8'h00;
      tile_sel    = 2'd0;
      flip_q      = 1'b0;
      scroll_ctl  = 8'h00;
      scroll_lo   = 8'h00;
   endfunction

   // Apply one bus access to the image and return the rsp word it yields.
   function automatic rsp_word_type predict_access(input access_type kind,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data);
      rsp_word_type w;
      int unsigned  slot;
      w = '0;
      if ((addr & WIN_SELECT) == WIN_BASE) begin
         // Bank 1 maps the window onto the low half, bank 0 onto the high half
         slot = int'(addr) & (HALF_BYTES - 1);
         if (!bank_direct)
            slot += HALF_BYTES;
         if (kind == ACCESS_READ)
            w.read_data = vram_img[slot];
         else if (bank_direct)
            vram_img[slot] = data;
         else
            vram_img[slot] = (vram_img[slot] & ~plane_sel) | (data & plane_sel);
      end else if (kind == ACCESS_WRITE) begin
         case (addr)
            REG_TILES: if ((data & TILE_LOCK) == 8'h00) tile_sel = data[1:0];
            PULSE_NMI:  w.main_nmi_pulse = 1'b1;
            PULSE_IRQC: w.own_irq_clear  = 1'b1;
            PULSE_NMIC: w.own_nmi_clear  = 1'b1;
            REG_FLIP:   flip_q     = data[0];
            REG_SCR_C:  scroll_ctl = data;
            REG_SCR_L:  scroll_lo  = data;
            REG_BANK: begin
               bank_direct = data[0];
               // Entering bank 0 picks one plane; a shift of 8 or more masks all
               if (!data[0])
                  plane_sel = (data[7:1] < 7'd8) ? 8'(1 << data[7:1]) : 8'h00;
            end
            default: ;
         endcase
      end
      w.flip_screen = flip_q;
      w.tile_bank   = tile_sel;
      w.bg_enable   = scroll_ctl[3];
      w.bg_scroll   = {scroll_ctl[1], scroll_lo};
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one access word and hold it until taken. Between bursts, drop
   // tvalid for a random gap; some bursts follow each other with no gap.
   task automatic send_access(input access_type kind, input logic [15:0] addr,
                              input logic [7:0] data);
      int unsigned gap;
      if (!sender_steady && burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {data, addr};
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(predict_access(kind, addr, data));
      if (burst_left > 0)
         burst_left--;
   endtask

   // Drop tvalid, then wait for every expected word plus the pipeline tail.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Store is clear after the sweep, reads outside the window return zero,
   // and reads of pulse addresses fire nothing.
   task automatic test_reset_state();
      send_access(ACCESS_READ, 16'hd000, 8'hff);
      send_access(ACCESS_READ, 16'hd7ff, 8'h00);
      send_access(ACCESS_READ, 16'h0000, 8'hff);
      send_access(ACCESS_READ, 16'hffff, 8'hff);
      send_access(ACCESS_READ, PULSE_NMI, 8'hff);
      send_access(ACCESS_READ, PULSE_NMIC, 8'hff);
      finish_phase();
   endtask

   // Display registers, the tile-bank lock bit, the three pulses, and a write
   // just past the window that must be ignored.
   task automatic test_display_regs();
      send_access(ACCESS_WRITE, REG_TILES, 8'hff);   // lock bit set: ignored
      send_access(ACCESS_WRITE, REG_TILES, 8'hfb);   // lock bit clear: bank 3
      send_access(ACCESS_WRITE, REG_FLIP, 8'hff);
      send_access(ACCESS_WRITE, REG_SCR_C, 8'hff);
      send_access(ACCESS_WRITE, REG_SCR_L, 8'hff);
      send_access(ACCESS_WRITE, PULSE_NMI, 8'h00);
      send_access(ACCESS_WRITE, PULSE_IRQC, 8'h00);
      send_access(ACCESS_WRITE, PULSE_NMIC, 8'h00);
      send_access(ACCESS_WRITE, 16'hd800, 8'haa);
      send_access(ACCESS_WRITE, REG_FLIP, 8'h00);
      finish_phase();
   endtask

   // Direct write to the low half, masked merges into the high half, the
   // all-masked case, and return to bank 1 keeping the mask.
   task automatic test_bank_merge();
      send_access(ACCESS_WRITE, 16'hd000, 8'hff);
      send_access(ACCESS_WRITE, REG_BANK, 8'h0e);    // bank 0, plane 7
      send_access(ACCESS_WRITE, 16'hd000, 8'hff);
      send_access(ACCESS_READ, 16'hd000, 8'h00);
      send_access(ACCESS_WRITE, REG_BANK, 8'h10);    // shift of 8: mask clear
      send_access(ACCESS_WRITE, 16'hd000, 8'h7f);
      send_access(ACCESS_WRITE, REG_BANK, 8'hfe);    // widest shift
      send_access(ACCESS_WRITE, REG_BANK, 8'h01);    // back to bank 1
      send_access(ACCESS_READ, 16'hd000, 8'h00);
      finish_phase();
   endtask

   // Mostly well-formed traffic: window accesses on a small hot set of
   // offsets so reads hit earlier writes, bank switches with useful shifts,
   // display registers and pulses, plus random bus noise.
   task automatic test_random_traffic();
      int unsigned useful;
      int unsigned sent;
      int unsigned pick;
      access_type  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [10:0] off;
      useful = 0;
      sent   = 0;
      // Open with a stretch where the sender never idles
      sender_steady = 1'b1;
      while (sent < RANDOM_WORDS) begin
         if (useful == 120)
            sender_steady = 1'b0;
         pick = $urandom_range(0, 99);
         kind = access_type'(1'($urandom));
         data = 8'($urandom);
         if (pick < 40) begin
            off  = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 15)) : 11'($urandom);
            addr = WIN_BASE | {5'd0, off};
            useful++;
         end else if (pick < 58) begin
            kind = ACCESS_WRITE;
            addr = REG_BANK;
            if ($urandom_range(0, 3) != 0)
               data = 8'(($urandom_range(0, 9) << 1) | $urandom_range(0, 1));
            useful++;
         end else if (pick < 75) begin
            case ($urandom_range(0, 3))
               0:       addr = REG_TILES;
               1:       addr = REG_FLIP;
               2:       addr = REG_SCR_C;
               default: addr = REG_SCR_L;
            endcase
            if ($urandom_range(0, 7) != 0)
               kind = ACCESS_WRITE;
            useful++;
         end else if (pick < 82) begin
            case ($urandom_range(0, 2))
               0:       addr = PULSE_NMI;
               1:       addr = PULSE_IRQC;
               default: addr = PULSE_NMIC;
            endcase
            useful++;
         end else begin
            addr = 16'($urandom);
         end
         send_access(kind, addr, data);
         sent++;
      end
      finish_phase();
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10)
            $display("Mismatch on rsp word %0d, %s: expected 0x%0h, got 0x%0h",
                     checked_cnt, field, want, got);
      end
   endtask

   // Check every taken rsp word against the oldest expectation.
   always @(posedge clock) begin : check_words
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_words.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("Unexpected rsp word 0x%0h with nothing pending", rsp_tdata);
         end else begin
            want = expected_words.pop_front();
            compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
            compare_field("main_nmi_pulse", 32'(want.main_nmi_pulse),
                          32'(got.main_nmi_pulse));
            compare_field("own_irq_clear", 32'(want.own_irq_clear),
                          32'(got.own_irq_clear));
            compare_field("own_nmi_clear", 32'(want.own_nmi_clear),
                          32'(got.own_nmi_clear));
            compare_field("flip_screen", 32'(want.flip_screen), 32'(got.flip_screen));
            compare_field("tile_bank", 32'(want.tile_bank), 32'(got.tile_bank));
            compare_field("bg_enable", 32'(want.bg_enable), 32'(got.bg_enable));
            compare_field("bg_scroll", 32'(want.bg_scroll), 32'(got.bg_scroll));
         end
         checked_cnt++;
      end
   end

   // Receiver stalls: rotate with cycle_cnt[8:7] through always ready, mostly
   // ready, mostly stalled, and a fixed five-of-eight pattern. Also run the
   // watchdog here.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words pending",
                  cycle_cnt, expected_words.size());
         $display("Test completed with failures");
         $finish;
      end
      case (cycle_cnt[8:7])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_cnt[2:0] < 3'd5);
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ACCESS_READ;
      req_tdata  <= '0;
      clear_image();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The clear sweep holds req_tready low; the first send waits it out
      test_reset_state();
      test_display_regs();
      test_bank_merge();
      test_random_traffic();

      if (mismatch_cnt == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
